/* hw/rtl/lsf_pkg.sv */
// lsf_pkg: shared constants, state encoding and control structs for the
// learning switch forwarding block. No dependencies.

package lsf_pkg;

    localparam int NUM_PORTS_DEF     = 4;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int MAC_W   = 48;
    localparam int ORDER_W = 32;
    localparam int CFG_W   = 3;

    localparam logic [CFG_W-1:0] CFG_PORTS_RESET = 3'd2;
    localparam logic [MAC_W-1:0] BCAST_MAC       = {MAC_W{1'b1}};

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic clear;
        logic vld;
    } scan_ctl_t;

    // Scan unit match flags back to the sequencer
    typedef struct packed {
        logic src_hit;
        logic dst_hit;
    } scan_flags_t;

endpackage

/* hw/rtl/lsf_table.sv */
// lsf_table: MAC table storage (MAC, port, learn order), one write port and
// one registered read port. Depends on lsf_pkg.

module lsf_table #(
    parameter int IDX_W  = 6,
    parameter int PORT_W = 2
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [lsf_pkg::MAC_W-1:0]    wr_mac,
    input  logic [PORT_W-1:0]            wr_port,
    input  logic [lsf_pkg::ORDER_W-1:0]  wr_order,
    input  logic                         re,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [lsf_pkg::MAC_W-1:0]    rd_mac,
    output logic [PORT_W-1:0]            rd_port,
    output logic [lsf_pkg::ORDER_W-1:0]  rd_order
);
    import lsf_pkg::*;

    localparam int DEPTH = 1 << IDX_W;
    localparam int ENT_W = MAC_W + PORT_W + ORDER_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= {wr_mac, wr_port, wr_order};
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_mac   = rd_data_reg[ENT_W-1 -: MAC_W];
    assign rd_port  = rd_data_reg[ORDER_W +: PORT_W];
    assign rd_order = rd_data_reg[ORDER_W-1:0];

endmodule

/* hw/rtl/lsf_scan.sv */
// lsf_scan: per-entry compare unit used once per swept entry; matches source
// and destination MACs and tracks the oldest entry. Depends on lsf_pkg.

module lsf_scan #(
    parameter int IDX_W  = 6,
    parameter int PORT_W = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsf_pkg::scan_ctl_t           ctl,
    input  logic [IDX_W-1:0]             idx,
    input  logic [lsf_pkg::MAC_W-1:0]    ent_mac,
    input  logic [PORT_W-1:0]            ent_port,
    input  logic [lsf_pkg::ORDER_W-1:0]  ent_order,
    input  logic [lsf_pkg::MAC_W-1:0]    src_mac,
    input  logic [lsf_pkg::MAC_W-1:0]    dst_mac,
    input  logic [lsf_pkg::ORDER_W-1:0]  seq,
    output lsf_pkg::scan_flags_t         flags,
    output logic [IDX_W-1:0]             src_idx,
    output logic [IDX_W-1:0]             dst_idx,
    output logic [PORT_W-1:0]            dst_port,
    output logic [IDX_W-1:0]             old_idx
);
    import lsf_pkg::*;

    scan_flags_t        flags_reg;
    logic               have_old_reg;
    logic [IDX_W-1:0]   src_idx_reg;
    logic [IDX_W-1:0]   dst_idx_reg;
    logic [PORT_W-1:0]  dst_port_reg;
    logic [IDX_W-1:0]   old_idx_reg;
    logic [ORDER_W-1:0] old_age_reg;

    logic [ORDER_W-1:0] age;
    logic               src_eq;
    logic               dst_eq;
    logic               older;

    // age wraps modulo 2^32, so the ordering survives counter wrap
    assign age    = seq - ent_order;
    assign src_eq = (ent_mac == src_mac);
    assign dst_eq = (ent_mac == dst_mac);
    assign older  = !have_old_reg || (age > old_age_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            have_old_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            flags_reg    <= '0;
            have_old_reg <= 1'b0;
        end
        else if (ctl.vld)
        begin
            if (src_eq)
            begin
                flags_reg.src_hit <= 1'b1;
            end
            if (dst_eq)
            begin
                flags_reg.dst_hit <= 1'b1;
            end
            have_old_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld && !ctl.clear)
        begin
            if (src_eq)
            begin
                src_idx_reg <= idx;
            end
            if (dst_eq)
            begin
                dst_idx_reg  <= idx;
                dst_port_reg <= ent_port;
            end
            // strict compare: ties keep the lower index
            if (older)
            begin
                old_idx_reg <= idx;
                old_age_reg <= age;
            end
        end
    end

    assign flags    = flags_reg;
    assign src_idx  = src_idx_reg;
    assign dst_idx  = dst_idx_reg;
    assign dst_port = dst_port_reg;
    assign old_idx  = old_idx_reg;

endmodule

/* hw/rtl/learning_switch_forwarding.sv */
// Learning switch forwarding: one item is accepted, then the table is swept
// one entry a cycle through the single read port, over the learned entries
// only (at most TABLE_ENTRIES; an empty table is not swept at all).
// The result strobe cannot be held off; a new item is taken in the cycle it
// shows. Reset empties the table at once (fill count to zero), clears the
// learn counter and sets ports_in_use to 2.

module learning_switch_forwarding #(
    parameter int NUM_PORTS     = lsf_pkg::NUM_PORTS_DEF,
    parameter int TABLE_ENTRIES = lsf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item in
    input  logic                              start,
    output logic                              busy,
    input  logic [$clog2(NUM_PORTS)-1:0]      ingress_port,
    input  logic [lsf_pkg::MAC_W-1:0]         source_mac,
    input  logic [lsf_pkg::MAC_W-1:0]         dest_mac,
    // result out, one-cycle strobe
    output logic                              result_valid,
    output logic [NUM_PORTS-1:0]              egress_mask,
    output logic                              table_hit,
    output logic                              flooded,
    output logic [$clog2(NUM_PORTS)-1:0]      learned_port,
    output logic                              evicted,
    // ports_in_use register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsf_pkg::CFG_W-1:0]         cfg_data
);
    import lsf_pkg::*;

    localparam int PORT_W = $clog2(NUM_PORTS);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    // Sequencer
    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    addr_reg;
    logic [CNT_W-1:0]    fill_reg;      // entries 0 .. fill-1 are valid
    logic [ORDER_W-1:0]  seq_reg;       // learn sequence, wraps
    logic [CFG_W-1:0]    ports_reg;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;

    // Latched item
    logic [PORT_W-1:0]   ing_reg;
    logic [MAC_W-1:0]    src_reg;
    logic [MAC_W-1:0]    dst_reg;

    // Result registers
    logic                done_reg;
    logic [NUM_PORTS-1:0] mask_reg;
    logic                hit_reg;
    logic                flood_reg;
    logic [PORT_W-1:0]   tgt_reg;
    logic                ev_reg;

    logic                accept;
    logic                last_rd;

    // Table and scan unit wiring
    logic [MAC_W-1:0]    rd_mac;
    logic [PORT_W-1:0]   rd_port;
    logic [ORDER_W-1:0]  rd_order;
    scan_ctl_t           scan_ctl;
    scan_flags_t         flags;
    logic [IDX_W-1:0]    src_idx;
    logic [IDX_W-1:0]    dst_idx;
    logic [PORT_W-1:0]   dst_port;
    logic [IDX_W-1:0]    old_idx;

    // Learn slot choice and forwarding decision, valid in ST_WRITE
    logic [IDX_W-1:0]    wr_slot;
    logic                grow;
    logic                ev;
    logic                is_bcast;
    logic                self_hit;
    logic                tbl_hit;
    logic                hit;
    logic [PORT_W-1:0]   tgt;
    logic [NUM_PORTS-1:0] act_mask;
    logic [NUM_PORTS-1:0] tgt_oh;
    logic [NUM_PORTS-1:0] ing_oh;
    logic [NUM_PORTS-1:0] mask;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign last_rd   = ((CNT_W'(addr_reg) + CNT_W'(1)) == fill_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // empty table: nothing to sweep
                    state_next = (fill_reg == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_rd)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign scan_ctl.clear = accept;
    assign scan_ctl.vld   = rd_vld_reg;

    lsf_table #(
        .IDX_W  (IDX_W),
        .PORT_W (PORT_W)
    ) u_table (
        .clk      (clk),
        .we       (state_reg == ST_WRITE),
        .wr_addr  (wr_slot),
        .wr_mac   (src_reg),
        .wr_port  (ing_reg),
        .wr_order (seq_reg),
        .re       (state_reg == ST_SCAN),
        .rd_addr  (addr_reg),
        .rd_mac   (rd_mac),
        .rd_port  (rd_port),
        .rd_order (rd_order)
    );

    lsf_scan #(
        .IDX_W  (IDX_W),
        .PORT_W (PORT_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .idx       (rd_idx_reg),
        .ent_mac   (rd_mac),
        .ent_port  (rd_port),
        .ent_order (rd_order),
        .src_mac   (src_reg),
        .dst_mac   (dst_reg),
        .seq       (seq_reg),
        .flags     (flags),
        .src_idx   (src_idx),
        .dst_idx   (dst_idx),
        .dst_port  (dst_port),
        .old_idx   (old_idx)
    );

    // Learn: rewrite an existing entry, else take the next free one, else
    // evict the oldest. Entries fill in index order, so the lowest free
    // entry is always the fill count.
    always_comb
    begin
        wr_slot = fill_reg[IDX_W-1:0];
        grow    = 1'b0;
        ev      = 1'b0;
        if (flags.src_hit)
        begin
            wr_slot = src_idx;
        end
        else if (fill_reg < CNT_W'(TABLE_ENTRIES))
        begin
            grow = 1'b1;
        end
        else
        begin
            wr_slot = old_idx;
            ev      = 1'b1;
        end
    end

    // Lookup runs on the table after the learn: the destination may be the
    // source just learned, and an evicted entry no longer matches.
    assign is_bcast = (dst_reg == BCAST_MAC);
    assign self_hit = (dst_reg == src_reg);
    assign tbl_hit  = flags.dst_hit && !(ev && (dst_idx == old_idx));
    assign hit      = !is_bcast && (self_hit || tbl_hit);

    always_comb
    begin
        tgt = '0;
        if (hit)
        begin
            tgt = self_hit ? ing_reg : dst_port;
        end
    end

    // Ports above the configured count are inactive; counts beyond
    // NUM_PORTS saturate naturally.
    always_comb
    begin
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            act_mask[i] = (int'(ports_reg) > i);
            tgt_oh[i]   = (tgt == PORT_W'(i));
            ing_oh[i]   = (ing_reg == PORT_W'(i));
        end
    end

    assign mask = hit ? (tgt_oh & act_mask) : (act_mask & ~ing_oh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            addr_reg   <= '0;
            fill_reg   <= '0;
            seq_reg    <= '0;
            ports_reg  <= CFG_PORTS_RESET;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN);
            done_reg   <= (state_reg == ST_WRITE);
            if (cfg_valid && cfg_ready)
            begin
                ports_reg <= cfg_data;
            end
            if (accept)
            begin
                addr_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            if (state_reg == ST_WRITE)
            begin
                seq_reg <= seq_reg + ORDER_W'(1);
                if (grow)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg;
        if (accept)
        begin
            ing_reg <= ingress_port;
            src_reg <= source_mac;
            dst_reg <= dest_mac;
        end
        if (state_reg == ST_WRITE)
        begin
            mask_reg  <= mask;
            hit_reg   <= hit;
            flood_reg <= !hit;
            tgt_reg   <= tgt;
            ev_reg    <= ev;
        end
    end

    assign result_valid = done_reg;
    assign egress_mask  = mask_reg;
    assign table_hit    = hit_reg;
    assign flooded      = flood_reg;
    assign learned_port = tgt_reg;
    assign evicted      = ev_reg;

endmodule

/* hw/rtl/lsf_checker.sv */
// lsf_checker: port-level assertions for learning_switch_forwarding, with the
// bind that attaches it. Depends on lsf_pkg and the top level.

module lsf_checker #(
    parameter int NUM_PORTS     = lsf_pkg::NUM_PORTS_DEF,
    parameter int TABLE_ENTRIES = lsf_pkg::TABLE_ENTRIES_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         result_valid,
    input logic                         table_hit,
    input logic                         flooded,
    input logic [$clog2(NUM_PORTS)-1:0] learned_port
);
    import lsf_pkg::*;

    localparam int DEPTH_CHK = TABLE_ENTRIES;

    // an accepted item keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accepted, depth %0d", DEPTH_CHK);

    // a result only follows a busy cycle
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without preceding work");

    // strobe lasts exactly one cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held");

    // each result either hits or floods, never both
    a_hit_xor_flood: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (table_hit != flooded))
        else $error("hit and flood disagree");

    // no learned port reported on a miss
    a_target_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !table_hit) |-> (learned_port == '0))
        else $error("learned port set without hit");

endmodule

bind learning_switch_forwarding lsf_checker #(
    .NUM_PORTS     (NUM_PORTS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_lsf_checker (.*);
